// ===== sv/spi_pkg.sv =====
// Package for the segment intersection point block: widths, item types.
// Used by every module of the block; depends on nothing.
package spi_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int CrossW = ProdW + 1;
  localparam int RemW   = CrossW + 2;
  localparam int QueueDepth = 4;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] dx;
    logic signed [CoordW-1:0] dy;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
  } out_item_t;

  // Classified work handed from the front to the back.
  typedef struct packed {
    logic                     hit;
    logic [CrossW-1:0]        den;
    logic [CrossW-1:0]        num;
    logic [DiffW-1:0]         mx;
    logic [DiffW-1:0]         my;
    logic                     negx;
    logic                     negy;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
  } work_t;

endpackage

// ===== sv/spi_front.sv =====
// Front of the segment intersection block: differences, cross products
// and the exact crossing test. Depends on spi_pkg.
module spi_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  spi_pkg::in_item_t in_item_i,
  output logic              push_o,
  input  logic              full_i,
  output spi_pkg::work_t    work_o
);

  localparam int DiffW  = spi_pkg::DiffW;
  localparam int ProdW  = spi_pkg::ProdW;
  localparam int CrossW = spi_pkg::CrossW;
  localparam int CoordW = spi_pkg::CoordW;

  logic adv;
  logic [3:0] v_q;

  logic signed [CoordW-1:0] ax1_q, ay1_q, ax2_q, ay2_q, ax3_q, ay3_q;
  logic signed [DiffW-1:0]  d0x_q, d0y_q, d1x_q, d1y_q, qx_q, qy_q;
  logic signed [DiffW-1:0]  d0x2_q, d0y2_q, d0x3_q, d0y3_q;
  logic signed [ProdW-1:0]  pda_q, pdb_q, pna_q, pnb_q, pma_q, pmb_q;
  logic signed [CrossW-1:0] den_q, n0_q, n1_q;
  spi_pkg::work_t work_q;

  logic                     neg;
  logic signed [CrossW-1:0] den_m, n0_m, n1_m;
  spi_pkg::work_t           work_d;

  assign adv        = !v_q[3] || !full_i;
  assign in_stall_o = !adv;
  assign push_o     = v_q[3] && !full_i;
  assign work_o     = work_q;

  always_comb begin
    neg   = den_q < 0;
    den_m = neg ? -den_q : den_q;
    n0_m  = neg ? -n0_q : n0_q;
    n1_m  = neg ? -n1_q : n1_q;
    work_d.hit  = (den_m != '0) && (n0_m > 0) && (n0_m < den_m) &&
                  (n1_m > 0) && (n1_m < den_m);
    work_d.den  = den_m;
    work_d.num  = n0_m;
    work_d.negx = d0x3_q < 0;
    work_d.negy = d0y3_q < 0;
    work_d.mx   = work_d.negx ? -d0x3_q : d0x3_q;
    work_d.my   = work_d.negy ? -d0y3_q : d0y3_q;
    work_d.ax   = ax3_q;
    work_d.ay   = ay3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax1_q <= in_item_i.ax;
      ay1_q <= in_item_i.ay;
      d0x_q <= DiffW'(in_item_i.bx) - DiffW'(in_item_i.ax);
      d0y_q <= DiffW'(in_item_i.by) - DiffW'(in_item_i.ay);
      d1x_q <= DiffW'(in_item_i.dx) - DiffW'(in_item_i.cx);
      d1y_q <= DiffW'(in_item_i.dy) - DiffW'(in_item_i.cy);
      qx_q  <= DiffW'(in_item_i.cx) - DiffW'(in_item_i.ax);
      qy_q  <= DiffW'(in_item_i.cy) - DiffW'(in_item_i.ay);

      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      d0x2_q <= d0x_q;
      d0y2_q <= d0y_q;
      pda_q  <= ProdW'(d0x_q) * ProdW'(d1y_q);
      pdb_q  <= ProdW'(d0y_q) * ProdW'(d1x_q);
      pna_q  <= ProdW'(qx_q) * ProdW'(d1y_q);
      pnb_q  <= ProdW'(qy_q) * ProdW'(d1x_q);
      pma_q  <= ProdW'(qx_q) * ProdW'(d0y_q);
      pmb_q  <= ProdW'(qy_q) * ProdW'(d0x_q);

      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      d0x3_q <= d0x2_q;
      d0y3_q <= d0y2_q;
      den_q  <= CrossW'(pda_q) - CrossW'(pdb_q);
      n0_q   <= CrossW'(pna_q) - CrossW'(pnb_q);
      n1_q   <= CrossW'(pma_q) - CrossW'(pmb_q);

      work_q <= work_d;
    end
  end

endmodule

// ===== sv/spi_queue.sv =====
// Short queue of classified work between the front and the back.
// Depends on spi_pkg.
module spi_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  spi_pkg::work_t work_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output spi_pkg::work_t work_o
);

  localparam int Depth = spi_pkg::QueueDepth;
  localparam int PtrW  = $clog2(Depth);

  spi_pkg::work_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = cnt_q == (PtrW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign work_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= work_i;
  end

endmodule

// ===== sv/spi_back.sv =====
// Back of the segment intersection block: pipelined scaled divider, one
// quotient bit per stage for each axis, and the output register. Depends on spi_pkg.
module spi_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  spi_pkg::work_t     work_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spi_pkg::out_item_t out_item_o
);

  localparam int DiffW  = spi_pkg::DiffW;
  localparam int CrossW = spi_pkg::CrossW;
  localparam int RemW   = spi_pkg::RemW;
  localparam int CoordW = spi_pkg::CoordW;
  localparam int Stages = DiffW;

  logic adv;
  logic [Stages:0] v_q;
  spi_pkg::work_t it_q [Stages+1];
  logic [RemW-1:0]  rx_q [Stages+1];
  logic [RemW-1:0]  ry_q [Stages+1];
  logic [DiffW-1:0] qx_q [Stages+1];
  logic [DiffW-1:0] qy_q [Stages+1];
  logic out_valid_q;
  spi_pkg::out_item_t out_q;

  logic signed [CoordW+1:0] px, py;

  // One restoring step; the partial remainder stays below three divisors.
  function automatic logic [RemW+DiffW-1:0] div_step(
    input logic [RemW-1:0]   r,
    input logic [DiffW-1:0]  q,
    input logic              mbit,
    input logic [CrossW-1:0] n,
    input logic [CrossW-1:0] d
  );
    logic [RemW-1:0] r2, d1, d2;
    r2 = {r[RemW-2:0], 1'b0} + (mbit ? RemW'(n) : '0);
    d1 = RemW'(d);
    d2 = {d1[RemW-2:0], 1'b0};
    if (r2 >= d2) begin
      div_step = {r2 - d2, {q[DiffW-2:0], 1'b0} + DiffW'(2)};
    end else if (r2 >= d1) begin
      div_step = {r2 - d1, {q[DiffW-2:0], 1'b1}};
    end else begin
      div_step = {r2, {q[DiffW-2:0], 1'b0}};
    end
  endfunction

  assign adv         = !out_valid_q || !out_stall_i;
  assign pop_o       = adv && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    px = it_q[Stages].negx ? (CoordW+2)'(it_q[Stages].ax) - (CoordW+2)'(qx_q[Stages])
                           : (CoordW+2)'(it_q[Stages].ax) + (CoordW+2)'(qx_q[Stages]);
    py = it_q[Stages].negy ? (CoordW+2)'(it_q[Stages].ay) - (CoordW+2)'(qy_q[Stages])
                           : (CoordW+2)'(it_q[Stages].ay) + (CoordW+2)'(qy_q[Stages]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q         <= {v_q[Stages-1:0], !empty_i};
      out_valid_q <= v_q[Stages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it_q[0] <= work_i;
      rx_q[0] <= '0;
      ry_q[0] <= '0;
      qx_q[0] <= '0;
      qy_q[0] <= '0;
      for (int k = 0; k < Stages; k++) begin
        it_q[k+1] <= it_q[k];
        {rx_q[k+1], qx_q[k+1]} <= div_step(rx_q[k], qx_q[k], it_q[k].mx[Stages-1-k],
                                           it_q[k].num, it_q[k].den);
        {ry_q[k+1], qy_q[k+1]} <= div_step(ry_q[k], qy_q[k], it_q[k].my[Stages-1-k],
                                           it_q[k].num, it_q[k].den);
      end
      out_q.hit <= it_q[Stages].hit;
      out_q.px  <= it_q[Stages].hit ? px[CoordW-1:0] : '0;
      out_q.py  <= it_q[Stages].hit ? py[CoordW-1:0] : '0;
    end
  end

endmodule

// ===== sv/segment_intersection_point.sv =====
// Segment intersection point, top level: front, queue and divider back end.
// Path in order: front registers, queue, divider stages and the output register.
// Throughput: one item per cycle while the receiver does not stall; the rate is set by the pipelined divider.
// Reset clears all valid flags and the queue pointers; no clearing pass.
// Depends on spi_pkg, spi_front, spi_queue and spi_back.
module segment_intersection_point (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spi_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spi_pkg::out_item_t out_item_o
);

  logic push, full, pop, empty;
  spi_pkg::work_t work_in, work_out;

  spi_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .push_o(push), .full_i(full), .work_o(work_in)
  );

  spi_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .work_i(work_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .work_o(work_out)
  );

  spi_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .work_i(work_out), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_item_o
  );

endmodule

// ===== sim/testbench.sv =====
// Testbench for segment_intersection_point: directed table plus random segment pairs,
// each result checked against a typed value or a cross-product predictor. Depends on spi_pkg and the RTL.
module testbench;

  typedef struct {
    spi_pkg::in_item_t  seg;
    bit                 typed;
    spi_pkg::out_item_t res;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  spi_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  spi_pkg::out_item_t out_item_o;

  spi_pkg::out_item_t pending_points[$];
  stim_row_t table_rows[$];
  int        error_count = 0;
  int        hit_count = 0;
  int        miss_count = 0;
  int        items_sent = 0;
  int        sender_idle_pct = 29;
  int        receiver_stall_pct = 70;
  bit        long_hold = 0;

  segment_intersection_point dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Truncation toward zero of the scaled quotient, applied to one axis.
  function automatic logic signed [spi_pkg::CoordW-1:0] lerp_coord(longint a, longint d,
                                                                  longint n, longint den);
    longint mag;
    longint q;
    longint p;
    mag = (d < 0) ? -d : d;
    q = (mag * n) / den;
    p = (d < 0) ? a - q : a + q;
    return p[spi_pkg::CoordW-1:0];
  endfunction

  function automatic spi_pkg::out_item_t crossing_point(spi_pkg::in_item_t s);
    longint d0x, d0y, d1x, d1y, qx, qy, den, n0, n1;
    spi_pkg::out_item_t r;
    d0x = longint'(s.bx) - longint'(s.ax);
    d0y = longint'(s.by) - longint'(s.ay);
    d1x = longint'(s.dx) - longint'(s.cx);
    d1y = longint'(s.dy) - longint'(s.cy);
    qx  = longint'(s.cx) - longint'(s.ax);
    qy  = longint'(s.cy) - longint'(s.ay);
    den = d0x * d1y - d0y * d1x;
    n0  = qx * d1y - qy * d1x;
    n1  = qx * d0y - qy * d0x;
    if (den < 0) begin
      den = -den;
      n0 = -n0;
      n1 = -n1;
    end
    r = '0;
    r.hit = (den != 0) && (n0 > 0) && (n0 < den) && (n1 > 0) && (n1 < den);
    if (r.hit) begin
      r.px = lerp_coord(longint'(s.ax), d0x, n0, den);
      r.py = lerp_coord(longint'(s.ay), d0y, n0, den);
    end
    return r;
  endfunction

  function automatic spi_pkg::in_item_t make_seg(int ax, int ay, int bx, int by,
                                                 int cx, int cy, int dx, int dy);
    spi_pkg::in_item_t s;
    s.ax = ax[spi_pkg::CoordW-1:0]; s.ay = ay[spi_pkg::CoordW-1:0];
    s.bx = bx[spi_pkg::CoordW-1:0]; s.by = by[spi_pkg::CoordW-1:0];
    s.cx = cx[spi_pkg::CoordW-1:0]; s.cy = cy[spi_pkg::CoordW-1:0];
    s.dx = dx[spi_pkg::CoordW-1:0]; s.dy = dy[spi_pkg::CoordW-1:0];
    return s;
  endfunction

  function automatic void add_row(spi_pkg::in_item_t s, bit typed, bit hit, int px, int py);
    stim_row_t row;
    row.seg = s;
    row.typed = typed;
    row.res.hit = hit;
    row.res.px = px[spi_pkg::CoordW-1:0];
    row.res.py = py[spi_pkg::CoordW-1:0];
    table_rows.push_back(row);
  endfunction

  function automatic int rand_span(int lim);
    return $urandom_range(2 * lim) - lim;
  endfunction

  // Pairs built to cross are the largest share; the rest are full-range noise, parallel pairs and tiny grids.
  function automatic spi_pkg::in_item_t random_pair();
    int kind, ax, ay, bx, by, mx, my, wx, wy;
    spi_pkg::in_item_t s;
    kind = $urandom_range(99);
    if (kind < 30) begin
      s = {$urandom, $urandom, $urandom, $urandom};
    end else if (kind < 70) begin
      ax = rand_span(16000); ay = rand_span(16000);
      bx = rand_span(16000); by = rand_span(16000);
      mx = (ax + bx) / 2; my = (ay + by) / 2;
      wx = rand_span(16000); wy = rand_span(16000);
      s = make_seg(ax, ay, bx, by, mx + wx, my + wy, mx - wx, my - wy);
    end else if (kind < 80) begin
      ax = rand_span(8000); ay = rand_span(8000);
      bx = rand_span(8000); by = rand_span(8000);
      mx = rand_span(8000); my = rand_span(8000);
      s = make_seg(ax, ay, bx, by, mx, my, mx + bx - ax, my + by - ay);
    end else begin
      s = make_seg(rand_span(8), rand_span(8), rand_span(8), rand_span(8),
                   rand_span(8), rand_span(8), rand_span(8), rand_span(8));
    end
    return s;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $time);
    error_count++;
  endtask

  task automatic send_segments(spi_pkg::in_item_t s, spi_pkg::out_item_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
    pending_points.push_back(want);
    items_sent++;
    if (want.hit) hit_count++; else miss_count++;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= long_hold || ($urandom_range(99) < receiver_stall_pct);
  end

  // One long hold-off of the receiver so the pipeline fills and stalls its input.
  initial begin
    wait (items_sent >= 200);
    @(posedge clk_i);
    long_hold = 1'b1;
    repeat (200) @(posedge clk_i);
    long_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    spi_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = pending_points.pop_front();
        if (out_item_o.hit !== want.hit) report_mismatch("hit", out_item_o.hit, want.hit);
        if (out_item_o.px !== want.px) report_mismatch("px", out_item_o.px, want.px);
        if (out_item_o.py !== want.py) report_mismatch("py", out_item_o.py, want.py);
      end
    end
  end

  initial begin
    #2000000;
    $display("Timeout waiting for results");
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int wait_cycles;
    spi_pkg::in_item_t s;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;

    // Typed rows: all-zero, plain crossing, endpoint touches, parallel, collinear, a disjoint miss and point segments.
    add_row(make_seg(0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0);
    add_row(make_seg(-10, 0, 10, 0, 0, -10, 0, 10), 1, 1, 0, 0);
    add_row(make_seg(0, 0, 10, 0, 10, -5, 10, 5), 1, 0, 0, 0);
    add_row(make_seg(0, 0, 10, 0, 5, 0, 5, 7), 1, 0, 0, 0);
    add_row(make_seg(0, 0, 10, 10, 0, 1, 10, 11), 1, 0, 0, 0);
    add_row(make_seg(0, 0, 10, 10, 2, 2, 20, 20), 1, 0, 0, 0);
    add_row(make_seg(0, 0, 10, 0, 20, -5, 20, 5), 1, 0, 0, 0);
    add_row(make_seg(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767), 1, 0, 0, 0);
    add_row(make_seg(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 1, 0, 0, 0);
    // Predicted rows: full-range diagonals, negative directions, truncation cases.
    add_row(make_seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 0, 0, 0, 0);
    add_row(make_seg(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767), 0, 0, 0, 0);
    add_row(make_seg(-32768, 0, 32767, 0, 0, -32768, 1, 32767), 0, 0, 0, 0);
    add_row(make_seg(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767), 0, 0, 0, 0);
    add_row(make_seg(0, 0, 3, 7, 0, 7, 3, 0), 0, 0, 0, 0);
    add_row(make_seg(5, 5, -6, -4, -6, 5, 5, -4), 0, 0, 0, 0);
    add_row(make_seg(-1, -1, 1, 1, -1, 1, 1, -1), 0, 0, 0, 0);
    add_row(make_seg(100, -3, -100, 4, 1, -50, -1, 50), 0, 0, 0, 0);
    add_row(make_seg(0, 0, 1, 1, 0, 1, 1, 0), 0, 0, 0, 0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i])
      send_segments(table_rows[i].seg,
                    table_rows[i].typed ? table_rows[i].res : crossing_point(table_rows[i].seg));

    for (int n = 0; n < 450; n++) begin
      if (n == 150) begin
        sender_idle_pct = 70;
        receiver_stall_pct = 29;
      end else if (n == 300) begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      s = random_pair();
      send_segments(s, crossing_point(s));
    end
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (pending_points.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (100) @(posedge clk_i);
    if (pending_points.size() != 0) report_mismatch("items left over", pending_points.size(), 0);

    $display("Sent %0d segment pairs: %0d crossings, %0d misses.", items_sent, hit_count,
             miss_count);
    $display("Covered parallel, endpoint, full-range and stall-heavy traffic.");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
